@@ rtl/irlq_pkg.sv @@
// Shared types and constants for the range linearizer and qualifier.
package irlq_pkg;

  localparam int COEF_W    = 64;
  localparam int DIST_W    = 32;
  localparam int NUM_COEFS = 7;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;

  // Readings below this are flagged invalid.
  localparam int VALID_MIN  = 120;
  // More than this many valid flags in the window raises bump.
  localparam int BUMP_LIMIT = 5;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic contact;
    logic bump;
  } win_stat_t;

endpackage

@@ rtl/ir_range_linearize_and_qualify.sv @@
// Top level of the range linearizer and qualifier: sequencer, coefficients, output register.
//
// Each request on the input channel carries one raw range reading. The block
// evaluates a degree-six calibration polynomial in Horner form over signed
// Q16.48 coefficients, saturating after every step, and rounds the result to
// a saturated Q16.16 distance. Alongside it, the reading is qualified against
// a floor of 120 (below it, qualified_value is -1), and a window of the last
// WINDOW_DEPTH valid flags gives contact and bump.
// Channels use valid/stall: a request moves when valid is high and stall low.
// The input takes a new request only while the sequencer is idle. The six
// Horner steps share one multiply-add unit, each step a multiply into a
// product register followed by an add and saturate. The finished result is
// loaded into the output register, and the sequencer then returns to idle
// before it takes the next request, so each request is finished before the
// next one is accepted.
// If the receiver stalls, the finished distance waits in the sequencer until
// the output register is free; the input stays stalled meanwhile.
// Coefficients are written over the cfg channel, always ready, by index 0
// (sixth power) to 6 (constant); other indexes are ignored. Reset clears the
// coefficients, the window and all control state.
module ir_range_linearize_and_qualify #(
  parameter int WINDOW_DEPTH = 30,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [SAMPLE_BITS-1:0]               raw_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [irlq_pkg::DIST_W-1:0]   distance,
  output logic signed [SAMPLE_BITS:0]          qualified_value,
  output logic                                 contact,
  output logic                                 bump,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [irlq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [irlq_pkg::COEF_W-1:0]          cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  localparam logic [irlq_pkg::STEP_W-1:0] LAST_STEP =
    irlq_pkg::STEP_W'(irlq_pkg::NUM_COEFS - 1);

  state_t                        state;
  logic [irlq_pkg::STEP_W-1:0]   step;
  irlq_pkg::coef_t               acc;
  irlq_pkg::coef_t               mac_sum;
  irlq_pkg::coef_t               coefs [irlq_pkg::NUM_COEFS];
  logic [SAMPLE_BITS-1:0]        sample;
  logic signed [SAMPLE_BITS:0]   qual;
  irlq_pkg::win_stat_t           win_next;
  irlq_pkg::win_stat_t           win_hold;
  logic                          in_accept;
  logic                          sample_ok;
  logic                          out_free;
  logic [irlq_pkg::DIST_W-1:0]   acc_top;
  logic signed [irlq_pkg::DIST_W-1:0] dist_round;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign sample_ok = (raw_sample >= SAMPLE_BITS'(irlq_pkg::VALID_MIN));

  // Coefficient registers; an index past the last coefficient is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < irlq_pkg::NUM_COEFS; i++) begin
        coefs[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 (32'(cfg_index) < 32'(irlq_pkg::NUM_COEFS))) begin
      coefs[cfg_index] <= cfg_data;
    end
  end

  irlq_mac #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mac (
    .clk    (clk),
    .mul_en (state == ST_MUL),
    .acc    (acc),
    .x      (sample),
    .coef   (coefs[step]),
    .sum_sat(mac_sum)
  );

  // The window advances when the request is taken, so the flags that go out
  // with this result are captured right then.
  irlq_window #(
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .update   (in_accept),
    .valid    (sample_ok),
    .stat_next(win_next)
  );

  // Round Q16.48 to Q16.16 with ties toward plus infinity; rounding up from
  // the largest positive value stays at the largest positive value.
  assign acc_top = acc[irlq_pkg::COEF_W-1:irlq_pkg::COEF_W-irlq_pkg::DIST_W];
  always_comb begin
    if ((acc_top == {1'b0, {(irlq_pkg::DIST_W-1){1'b1}}}) &&
        acc[irlq_pkg::COEF_W-irlq_pkg::DIST_W-1]) begin
      dist_round = acc_top;
    end else begin
      dist_round = acc_top + irlq_pkg::DIST_W'(acc[irlq_pkg::COEF_W-irlq_pkg::DIST_W-1]);
    end
  end

  // Sequencer: a multiply state and then an add state for each Horner step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_MUL;
            step  <= irlq_pkg::STEP_W'(1);
          end
        end
        ST_MUL: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end else begin
            state <= ST_MUL;
            step  <= step + irlq_pkg::STEP_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      acc      <= coefs[0];
      sample   <= raw_sample;
      qual     <= sample_ok ? $signed({1'b0, raw_sample}) : '1;
      win_hold <= win_next;
    end else if (state == ST_ADD) begin
      acc <= mac_sum;
    end
  end

  // Output register; it drains independently of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      distance        <= dist_round;
      qualified_value <= qual;
      contact         <= win_hold.contact;
      bump            <= win_hold.bump;
    end
  end

  // An add cycle always follows the multiply cycle of the same step.
  a_add_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |-> ($past(state) == ST_MUL))
    else $error("add cycle without a preceding multiply");

  // While busy, the step counter points at one of the six added coefficients.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_MUL) || (state == ST_ADD)) |->
      ((step >= irlq_pkg::STEP_W'(1)) && (step <= LAST_STEP)))
    else $error("Horner step counter out of range");

  // The sequencer finishes only after the last Horner step.
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && ($past(state) != ST_DONE)) |->
      (($past(state) == ST_ADD) && ($past(step) == LAST_STEP)))
    else $error("result finished before all Horner steps");

  // A new result appears only when the sequencer hands one over.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("output valid raised without a finished result");

endmodule

@@ rtl/irlq_mac.sv @@
// Shared multiply-add unit for one Horner step: product register, then add and saturate.
module irlq_mac #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   mul_en,
  input  irlq_pkg::coef_t        acc,
  input  logic [SAMPLE_BITS-1:0] x,
  input  irlq_pkg::coef_t        coef,
  output irlq_pkg::coef_t        sum_sat
);

  localparam int PW = irlq_pkg::COEF_W + SAMPLE_BITS + 1;
  localparam int SW = PW + 1;
  localparam int HW = SW - irlq_pkg::COEF_W + 1;

  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] sum;
  logic        [HW-1:0] top_bits;

  // The sample is unsigned, so it enters the signed product with a zero on top.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PW'(acc) * PW'($signed({1'b0, x}));
    end
  end

  assign sum      = SW'(prod) + SW'(coef);
  assign top_bits = sum[SW-1:irlq_pkg::COEF_W-1];

  // The sum fits in 64 bits only when all bits from bit 63 upward agree.
  always_comb begin
    if ((top_bits == '0) || (top_bits == '1)) begin
      sum_sat = sum[irlq_pkg::COEF_W-1:0];
    end else if (sum[SW-1]) begin
      sum_sat = {1'b1, {(irlq_pkg::COEF_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(irlq_pkg::COEF_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/irlq_window.sv @@
// Sliding window of valid flags with a running count of set flags.
module irlq_window #(
  parameter int DEPTH = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                update,
  input  logic                valid,
  output irlq_pkg::win_stat_t stat_next
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0] flags;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // The oldest flag leaves at the bottom while the new one enters at the top.
  assign count_next = count - CNT_W'(flags[0]) + CNT_W'(valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      count <= '0;
    end else if (update) begin
      flags <= {valid, flags[DEPTH-1:1]};
      count <= count_next;
    end
  end

  assign stat_next.contact = valid;
  assign stat_next.bump    = (32'(count_next) > 32'(irlq_pkg::BUMP_LIMIT));

endmodule
